// ===== hdl/adne_pkg.sv =====
// Shared types and constants for the advertising data local name extractor.
package adne_pkg;

  // Field type codes that carry a local name.
  localparam logic [7:0] TYPE_NAME_SHORT    = 8'h08;
  localparam logic [7:0] TYPE_NAME_COMPLETE = 8'h09;

  // Reset value of the maximum name length register.
  localparam logic [7:0] MAX_NAME_LEN_RST = 8'd29;

  // Parse outcome reported with each result.
  typedef enum logic [1:0] {
    OUT_PARSING   = 2'd0,
    OUT_FOUND     = 2'd1,
    OUT_NONAME    = 2'd2,
    OUT_MALFORMED = 2'd3
  } outcome_t;

  // One result transaction.
  typedef struct packed {
    logic [7:0] name_byte;
    logic       is_name;
    logic       finished;
    outcome_t   outcome;
    logic [7:0] name_count;
  } res_t;

endpackage

// ===== hdl/adv_data_name_extractor_core.sv =====
// Advertising data local name extractor: parser state, result register and skid stage.
//
// Accepts one advertising data byte per clock while in_stall is low and returns
// exactly one result transaction per byte. Each result is computed in the same
// cycle the byte is taken, from the byte and the parser counters, and is
// registered in the output register, or in the skid stage while the output is
// held. A second result register (skid stage) lets the input keep taking
// a byte while the output is stalled; in_stall rises only when both registers
// hold results. The parser walks length-type-value fields, hands out local name
// bytes (shortened or complete name) up to cfg max length, and reports found,
// no name or malformed on the finishing byte. cfg_wr_en must only be used while
// no results are pending.
module adv_data_name_extractor_core
  import adne_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // Configuration
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  // Input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_first_byte,
  input  logic [7:0] in_record_length,
  // Result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_name_byte,
  output logic       out_is_name,
  output logic       out_finished,
  output logic [1:0] out_outcome,
  output logic [7:0] out_name_count
);

  typedef enum logic [2:0] {
    PH_DONE = 3'd0,
    PH_LEN  = 3'd1,
    PH_TYPE = 3'd2,
    PH_SKIP = 3'd3,
    PH_NAME = 3'd4
  } phase_t;

  // Parser state and configuration.
  phase_t     phase_r, phase_nxt;
  logic [7:0] record_left_r, record_left_nxt;
  logic [7:0] field_left_r, field_left_nxt;
  logic [7:0] copy_left_r, copy_left_nxt;
  logic [7:0] copied_r, copied_nxt;
  logic [7:0] max_name_len_r;

  // Output register and skid stage.
  logic       out_valid_r, out_valid_nxt;
  logic       skid_valid_r, skid_valid_nxt;
  res_t       out_res_r, out_res_nxt;
  res_t       skid_res_r, skid_res_nxt;
  res_t       res;

  logic       in_acc;
  logic       out_take;

  assign in_acc   = in_valid && !skid_valid_r;
  assign out_take = out_valid_r && !out_stall;

  // Parser step for the byte on the input.
  always_comb begin
    phase_t     ph;
    logic [7:0] rl;
    logic [7:0] fl;
    logic [7:0] cl;
    logic [7:0] cp;
    logic [7:0] rl_dec;
    logic [7:0] fl_dec;
    logic [7:0] cl_dec;
    outcome_t   oc;
    logic       is_nm;

    ph    = phase_r;
    rl    = record_left_r;
    fl    = field_left_r;
    cl    = copy_left_r;
    cp    = copied_r;
    oc    = OUT_PARSING;
    is_nm = 1'b0;

    // A first byte restarts the record.
    if (in_first_byte) begin
      cp = 8'd0;
      fl = 8'd0;
      cl = 8'd0;
      rl = in_record_length;
      if (in_record_length == 8'd0) begin
        ph = PH_DONE;
        oc = OUT_NONAME;
      end else begin
        ph = PH_LEN;
      end
    end

    rl_dec = rl - 8'd1;
    fl_dec = fl - 8'd1;
    cl_dec = cl - 8'd1;

    if (ph != PH_DONE && rl != 8'd0) begin
      rl = rl_dec;
      unique case (ph)
        PH_LEN: begin
          if (in_data_byte == 8'd0) begin
            ph = PH_DONE;
            oc = OUT_NONAME;
          end else if (in_data_byte > rl_dec) begin
            ph = PH_DONE;
            oc = OUT_MALFORMED;
          end else begin
            fl = in_data_byte - 8'd1;
            ph = PH_TYPE;
          end
        end
        PH_TYPE: begin
          if (in_data_byte == TYPE_NAME_SHORT || in_data_byte == TYPE_NAME_COMPLETE) begin
            cl = (fl < max_name_len_r) ? fl : max_name_len_r;
            if (cl == 8'd0) begin
              ph = PH_DONE;
              oc = OUT_FOUND;
            end else begin
              ph = PH_NAME;
            end
          end else if (fl == 8'd0) begin
            if (rl_dec == 8'd0) begin
              ph = PH_DONE;
              oc = OUT_NONAME;
            end else begin
              ph = PH_LEN;
            end
          end else begin
            ph = PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (fl != 8'd0) begin
            fl = fl_dec;
          end
          if (fl == 8'd0) begin
            if (rl_dec == 8'd0) begin
              ph = PH_DONE;
              oc = OUT_NONAME;
            end else begin
              ph = PH_LEN;
            end
          end
        end
        PH_NAME: begin
          is_nm = 1'b1;
          cp    = cp + 8'd1;
          if (cl != 8'd0) begin
            cl = cl_dec;
          end
          if (cl == 8'd0) begin
            ph = PH_DONE;
            oc = OUT_FOUND;
          end
        end
        default: begin
          ph = PH_DONE;
        end
      endcase
    end else if (ph != PH_DONE) begin
      // Active phase with no bytes left; close the record quietly.
      ph = PH_DONE;
      oc = OUT_NONAME;
    end

    phase_nxt       = ph;
    record_left_nxt = rl;
    field_left_nxt  = fl;
    copy_left_nxt   = cl;
    copied_nxt      = cp;

    res.name_byte  = is_nm ? in_data_byte : 8'd0;
    res.is_name    = is_nm;
    res.finished   = (oc != OUT_PARSING);
    res.outcome    = oc;
    res.name_count = cp;
  end

  // Output register and skid stage steering.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_res_nxt    = out_res_r;
    skid_valid_nxt = skid_valid_r;
    skid_res_nxt   = skid_res_r;
    if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_res_nxt    = skid_res_r;
        skid_valid_nxt = 1'b0;
      end else if (in_acc) begin
        out_valid_nxt = 1'b1;
        out_res_nxt   = res;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (in_acc) begin
      skid_valid_nxt = 1'b1;
      skid_res_nxt   = res;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_DONE;
      record_left_r  <= 8'd0;
      field_left_r   <= 8'd0;
      copy_left_r    <= 8'd0;
      copied_r       <= 8'd0;
      max_name_len_r <= MAX_NAME_LEN_RST;
      out_valid_r    <= 1'b0;
      skid_valid_r   <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_r       <= phase_nxt;
        record_left_r <= record_left_nxt;
        field_left_r  <= field_left_nxt;
        copy_left_r   <= copy_left_nxt;
        copied_r      <= copied_nxt;
      end
      if (cfg_wr_en) begin
        max_name_len_r <= cfg_wr_data;
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign in_stall       = skid_valid_r;
  assign out_valid      = out_valid_r;
  assign out_name_byte  = out_res_r.name_byte;
  assign out_is_name    = out_res_r.is_name;
  assign out_finished   = out_res_r.finished;
  assign out_outcome    = out_res_r.outcome;
  assign out_name_count = out_res_r.name_count;

  // The skid stage only fills behind a held output.
  a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage valid while output register empty");

  // An active parse phase always has record bytes left.
  a_active_has_bytes : assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_DONE) |-> (record_left_r != 8'd0))
    else $error("active phase with empty record");

  // Name copying always has at least one byte to go.
  a_name_has_copy : assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_NAME) |-> (copy_left_r != 8'd0))
    else $error("name phase with zero copy count");

  // A name byte is counted and never ends the record as no name or malformed.
  a_name_result : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.is_name) |->
      (out_res_r.name_count != 8'd0 &&
       (out_res_r.outcome == OUT_PARSING || out_res_r.outcome == OUT_FOUND)))
    else $error("inconsistent name result");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the advertising data local name extractor core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import adne_pkg::*;

  // Parser phases of the predictor.
  typedef enum logic [2:0] {
    PH_DONE,
    PH_LEN,
    PH_TYPE,
    PH_SKIP,
    PH_NAME
  } parse_phase_t;

  typedef logic [7:0] byte_q_t[$];

  // Predicts one result transaction per data byte and checks the results against it.
  class name_scoreboard;
    logic [7:0]   max_len;
    parse_phase_t phase;
    logic [7:0]   record_left;
    logic [7:0]   field_left;
    logic [7:0]   copy_left;
    logic [7:0]   copied;
    res_t         expected_results[$];
    int           mismatches;

    function new();
      max_len     = MAX_NAME_LEN_RST;
      phase       = PH_DONE;
      record_left = '0;
      field_left  = '0;
      copy_left   = '0;
      copied      = '0;
      mismatches  = 0;
    endfunction

    // A field is used up: either the record ends here or another length byte follows.
    function outcome_t close_field();
      if (record_left == 8'd0) begin
        phase = PH_DONE;
        return OUT_NONAME;
      end
      phase = PH_LEN;
      return OUT_PARSING;
    endfunction

    // Notes an accepted data byte; returns 1 when the byte is not simply ignored.
    function bit note_byte(logic [7:0] b, logic first, logic [7:0] rlen);
      res_t want;
      bit   active;
      want         = '0;
      want.outcome = OUT_PARSING;
      active       = first || (phase != PH_DONE);

      // A first byte restarts the parse with a fresh record length.
      if (first) begin
        copied      = '0;
        field_left  = '0;
        copy_left   = '0;
        record_left = rlen;
        if (rlen == 8'd0) begin
          phase        = PH_DONE;
          want.outcome = OUT_NONAME;
        end else begin
          phase = PH_LEN;
        end
      end

      if (phase != PH_DONE && record_left != 8'd0) begin
        record_left = record_left - 8'd1;
        case (phase)
          PH_LEN: begin
            if (b == 8'd0) begin
              phase        = PH_DONE;
              want.outcome = OUT_NONAME;
            end else if (b > record_left) begin
              phase        = PH_DONE;
              want.outcome = OUT_MALFORMED;
            end else begin
              field_left = b - 8'd1;
              phase      = PH_TYPE;
            end
          end
          PH_TYPE: begin
            if (b == TYPE_NAME_SHORT || b == TYPE_NAME_COMPLETE) begin
              copy_left = (field_left < max_len) ? field_left : max_len;
              if (copy_left == 8'd0) begin
                phase        = PH_DONE;
                want.outcome = OUT_FOUND;
              end else begin
                phase = PH_NAME;
              end
            end else if (field_left == 8'd0) begin
              want.outcome = close_field();
            end else begin
              phase = PH_SKIP;
            end
          end
          PH_SKIP: begin
            if (field_left != 8'd0) field_left = field_left - 8'd1;
            if (field_left == 8'd0) want.outcome = close_field();
          end
          PH_NAME: begin
            want.is_name   = 1'b1;
            want.name_byte = b;
            copied         = copied + 8'd1;
            if (copy_left != 8'd0) copy_left = copy_left - 8'd1;
            if (copy_left == 8'd0) begin
              phase        = PH_DONE;
              want.outcome = OUT_FOUND;
            end
          end
          default: phase = PH_DONE;
        endcase
      end else if (phase != PH_DONE) begin
        phase        = PH_DONE;
        want.outcome = OUT_NONAME;
      end

      want.finished   = (want.outcome != OUT_PARSING);
      want.name_count = copied;
      expected_results.push_back(want);
      return active;
    endfunction

    // Compares one result transaction with the oldest expectation.
    function void check_result(res_t got);
      res_t want;
      if (expected_results.size() == 0) begin
        $error("result transaction arrived with no expectation pending");
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      if (got.name_byte !== want.name_byte) begin
        $error("name_byte: expected %0d, actual %0d", want.name_byte, got.name_byte);
        mismatches++;
      end
      if (got.is_name !== want.is_name) begin
        $error("is_name: expected %0d, actual %0d", want.is_name, got.is_name);
        mismatches++;
      end
      if (got.finished !== want.finished) begin
        $error("finished: expected %0d, actual %0d", want.finished, got.finished);
        mismatches++;
      end
      if (got.outcome !== want.outcome) begin
        $error("outcome: expected %0d, actual %0d", want.outcome, got.outcome);
        mismatches++;
      end
      if (got.name_count !== want.name_count) begin
        $error("name_count: expected %0d, actual %0d", want.name_count, got.name_count);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_data_byte;
  logic       in_first_byte;
  logic [7:0] in_record_length;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_name_byte;
  logic       out_is_name;
  logic       out_finished;
  logic [1:0] out_outcome;
  logic [7:0] out_name_count;

  name_scoreboard board = new();
  bit idle_on = 1'b1;
  int parsed_items = 0;

  adv_data_name_extractor_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_first_byte    (in_first_byte),
    .in_record_length (in_record_length),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_name_byte    (out_name_byte),
    .out_is_name      (out_is_name),
    .out_finished     (out_finished),
    .out_outcome      (out_outcome),
    .out_name_count   (out_name_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result side: random stall bursts while idling is enabled.
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!idle_on) begin
        stall_left = 0;
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 17);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Every accepted result transaction goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_result(res_t'({out_name_byte, out_is_name, out_finished, out_outcome,
                                 out_name_count}));
    end
  end

  // Offers one data byte, with an optional idle burst first, and waits for acceptance.
  task automatic drive_item(input logic [7:0] b, input logic first, input logic [7:0] rlen);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_data_byte     <= b;
    in_first_byte    <= first;
    in_record_length <= rlen;
    do @(posedge clk); while (in_stall);
    void'(board.note_byte(b, first, rlen));
    parsed_items++;
  endtask

  task automatic send_record(input byte_q_t rec, input logic [7:0] rlen);
    foreach (rec[i]) begin
      drive_item(rec[i], i == 0, (i == 0) ? rlen : 8'($urandom_range(0, 255)));
    end
  endtask

  // Holds the sender off until every pending result transaction has arrived.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_max_len(input logic [7:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.max_len = v;
  endtask

  // Builds a chain of length-type-value fields, mostly well formed.
  task automatic build_record(input int name_max, output byte_q_t rec,
                              output logic [7:0] rlen);
    int         nfields;
    int         vlen;
    int         total;
    logic [7:0] ftype;
    rec = {};
    nfields = $urandom_range(0, 4);
    for (int i = 0; i < nfields; i++) begin
      if ($urandom_range(0, 9) < 4) begin
        ftype = $urandom_range(0, 1) ? TYPE_NAME_SHORT : TYPE_NAME_COMPLETE;
        vlen  = ($urandom_range(0, 14) == 0) ? $urandom_range(0, name_max)
                                             : $urandom_range(0, 8);
      end else begin
        ftype = 8'($urandom_range(0, 255));
        vlen  = $urandom_range(0, 6);
      end
      rec.push_back(8'(vlen + 1));
      rec.push_back(ftype);
      repeat (vlen) rec.push_back(8'($urandom_range(0, 255)));
    end
    // A zero length byte ends the chain early.
    if ($urandom_range(0, 9) == 0) begin
      rec.push_back(8'h00);
      repeat ($urandom_range(0, 2)) rec.push_back(8'($urandom_range(0, 255)));
    end
    if (rec.size() == 0) rec.push_back(8'($urandom_range(0, 255)));
    while (rec.size() > 255) void'(rec.pop_back());
    total = rec.size();
    case ($urandom_range(0, 9))
      0: rlen = 8'(((total + $urandom_range(1, 4)) > 255) ? 255 : total + $urandom_range(1, 4));
      1: rlen = 8'($urandom_range(0, total));
      default: rlen = 8'(total);
    endcase
  endtask

  initial begin
    #10ms;
    $display("adv_data_name_extractor_core: mismatch");
    $finish;
  end

  initial begin
    byte_q_t    rec;
    logic [7:0] rlen;
    logic [7:0] phase_max[6];
    int         start_items;
    int         name_max;
    bit         paused;

    rst_n            <= 1'b0;
    cfg_wr_en        <= 1'b0;
    cfg_wr_data      <= '0;
    in_valid         <= 1'b0;
    in_data_byte     <= '0;
    in_first_byte    <= 1'b0;
    in_record_length <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed records at the reset maximum name length.
    send_record({8'hFF}, 8'd0);                                     // empty record
    drive_item(8'h00, 1'b0, 8'hFF);                                 // ignored after finish
    send_record({8'h00}, 8'd255);                                   // zero length byte
    send_record({8'h03, 8'h01}, 8'd2);                              // field longer than record
    send_record({8'h02, 8'h01, 8'h06, 8'h03, TYPE_NAME_COMPLETE, 8'h41, 8'h42}, 8'd7);
    send_record({8'h02, 8'hFF, 8'h80}, 8'd3);                       // last field ends record
    send_record({8'h01, TYPE_NAME_SHORT}, 8'd2);                    // empty name
    send_record({8'h01, 8'h01, 8'h01, 8'h02}, 8'd4);                // type-only fields
    send_record({8'h03, TYPE_NAME_COMPLETE, 8'h7A}, 8'd8);          // cut by the next record

    phase_max = '{8'd0, 8'd255, 8'd1, 8'd29, 8'($urandom_range(2, 254)), 8'd3};
    for (int p = 0; p < 6; p++) begin
      wait_drained();
      set_max_len(phase_max[p]);
      start_items = parsed_items;
      paused      = 1'b0;
      name_max    = (phase_max[p] == 8'd255) ? 250 : 40;
      while (parsed_items - start_items < 240) begin
        idle_on = (p < 5) && ($urandom_range(0, 7) != 0);
        if (!paused && parsed_items - start_items >= 120) begin
          wait_drained();
          paused = 1'b1;
        end
        if ($urandom_range(0, 9) == 0) begin
          // Noise: random bytes with the occasional stray first byte.
          repeat ($urandom_range(1, 4)) begin
            drive_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                       8'($urandom_range(0, 255)));
          end
        end else begin
          build_record(name_max, rec, rlen);
          if ($urandom_range(0, 9) == 0) begin
            while (rec.size() > 1 && $urandom_range(0, 2) != 0) void'(rec.pop_back());
          end
          send_record(rec, rlen);
          if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) begin
              drive_item(8'($urandom_range(0, 255)), 1'b0, 8'($urandom_range(0, 255)));
            end
          end
        end
      end
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (board.mismatches == 0 && board.expected_results.size() == 0) begin
      $display("adv_data_name_extractor_core: match");
    end else begin
      $display("adv_data_name_extractor_core: mismatch");
    end
    $finish;
  end

endmodule
